@@ hw/rtl/lavm_pkg.sv @@
// shared types and constants for the look-at view matrix pipeline
package lavm_pkg;

  localparam int unsigned COORD_W             = 32;
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  localparam int unsigned ROT_W               = 16;
  localparam int unsigned ROT_FRAC            = 14;
  localparam int unsigned UNIT_BITS           = 28;
  localparam int unsigned UNIT_W              = UNIT_BITS + 2;
  localparam int unsigned NRM_W               = 24;

  // stage counts of the sub-units
  localparam int unsigned NORM_LAT  = 61;
  localparam int unsigned CROSS_LAT = 2;
  localparam int unsigned DEGEN_LAT = 3;

  // 1e-6 in Q.60, rounded up
  localparam logic [63:0] DEGEN_LIMIT = 64'd1152921504607;

  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ROT_W-1:0]   rot_t;

  localparam unit_t UNIT_ONE = unit_t'(1 << UNIT_BITS);

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t upvec_x;
    coord_t upvec_y;
    coord_t upvec_z;
  } view_req_t;

  typedef struct packed {
    rot_t   side_x;
    rot_t   side_y;
    rot_t   side_z;
    rot_t   trueup_x;
    rot_t   trueup_y;
    rot_t   trueup_z;
    rot_t   fwd_x;
    rot_t   fwd_y;
    rot_t   fwd_z;
    coord_t shift_side;
    coord_t shift_up;
    coord_t shift_fwd;
  } view_mat_t;

endpackage

@@ hw/rtl/look_at_view_matrix.sv @@
// look-at view matrix pipeline
// throughput one item per cycle while no output stall holds it, set by the fully pipelined normalizers
// (25 square-root stages and 29 divide stages each, three in series)
// a stall at the output, while a result is waiting there, freezes the whole pipeline in place
// reset clears all valid bits; payload registers are not reset
module look_at_view_matrix #(
  parameter int unsigned COORD_FRAC_BITS = lavm_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lavm_pkg::view_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lavm_pkg::view_mat_t out_data_o
);

  localparam int unsigned CW  = lavm_pkg::COORD_W;
  localparam int unsigned UW  = lavm_pkg::UNIT_W;
  localparam int unsigned UB  = lavm_pkg::UNIT_BITS;
  localparam int unsigned RW  = lavm_pkg::ROT_W;
  localparam int unsigned RSH = UB - lavm_pkg::ROT_FRAC;
  localparam int unsigned NL  = lavm_pkg::NORM_LAT;
  localparam int unsigned CL  = lavm_pkg::CROSS_LAT;
  localparam int unsigned DL  = lavm_pkg::DEGEN_LAT;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned SW  = UW + CW + 1;
  localparam int unsigned TW  = UW + UW + 1;
  localparam int unsigned PW  = UW + CW;
  localparam int unsigned D_F1  = CL + NL + 1;
  localparam int unsigned D_S   = CL + NL;
  localparam int unsigned D_EYE = 3 * NL + 2 * CL + 1;

  function automatic lavm_pkg::rot_t rnd_rot(input lavm_pkg::unit_t v);
    logic [UW-1:0] mag;
    logic [UW-1:0] r;
    mag = v[UW-1] ? UW'(-v) : UW'(v);
    r   = (mag + (UW'(1) << (RSH - 1))) >> RSH;
    if (!v[UW-1]) begin
      rnd_rot = (r > UW'(32767)) ? 16'sh7fff : RW'(r);
    end else begin
      rnd_rot = (r > UW'(32768)) ? 16'sh8000 : RW'(~r + UW'(1));
    end
  endfunction

  function automatic lavm_pkg::coord_t rnd_shift(input logic signed [63:0] d);
    logic [63:0] mag;
    logic [63:0] r;
    mag = d[63] ? 64'(-d) : 64'(d);
    r   = (mag + (64'(1) << (UB - 1))) >> UB;
    if (!d[63]) begin
      rnd_shift = (r > 64'h7fff_ffff) ? 32'sh7fff_ffff : CW'(r);
    end else begin
      rnd_shift = (r > 64'h8000_0000) ? 32'sh8000_0000 : CW'(~r + 64'd1);
    end
  endfunction

  logic en;
  logic out_valid_q;
  lavm_pkg::view_mat_t out_data_q;

  assign en = !out_valid_q || !out_stall_i;

  // input stage
  logic                  vld_a_q;
  lavm_pkg::coord_t      eye_in [3];
  lavm_pkg::coord_t      tgt_in [3];
  lavm_pkg::coord_t      up_in  [3];
  lavm_pkg::coord_t      eye_a_q [3];
  lavm_pkg::coord_t      up_a_q  [3];
  logic signed [DW-1:0]  diff_a_q [3];

  always_comb begin
    eye_in[0] = in_data_i.eye_x;
    eye_in[1] = in_data_i.eye_y;
    eye_in[2] = in_data_i.eye_z;
    tgt_in[0] = in_data_i.target_x;
    tgt_in[1] = in_data_i.target_y;
    tgt_in[2] = in_data_i.target_z;
    up_in[0]  = in_data_i.upvec_x;
    up_in[1]  = in_data_i.upvec_y;
    up_in[2]  = in_data_i.upvec_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye_a_q[i]  <= eye_in[i];
        up_a_q[i]   <= up_in[i];
        diff_a_q[i] <= DW'(tgt_in[i]) - DW'(eye_in[i]);
      end
    end
  end

  // forward vector
  logic            vld_f;
  lavm_pkg::unit_t f_v [3];

  lavm_norm #(.WI(DW)) u_nrm_fwd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_a_q),
    .v_i   (diff_a_q),
    .vld_o (vld_f),
    .u_o   (f_v)
  );

  logic [3*CW-1:0]  up_dq;
  lavm_pkg::coord_t up_d [3];

  lavm_dly #(.W(3*CW), .D(NL)) u_dly_up (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({up_a_q[2], up_a_q[1], up_a_q[0]}),
    .q_o  (up_dq)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_d[i] = $signed(up_dq[i*CW +: CW]);
    end
  end

  // raw side vector
  logic                 vld_c1;
  logic signed [SW-1:0] sraw [3];

  lavm_cross #(.WA(UW), .WB(CW)) u_crs_side (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_f),
    .a_i   (f_v),
    .b_i   (up_d),
    .vld_o (vld_c1),
    .o_o   (sraw)
  );

  // degeneracy test on the raw side vector
  logic [30:0] dm1_q [3];
  logic [2:0]  big1_q;
  logic [61:0] dsq2_q [3];
  logic        big2_q;
  logic        degen3_q;
  logic        degen_d;

  always_ff @(posedge clk_i) begin
    logic [SW-1:0] mag;
    logic [63:0]   rnd;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag = sraw[i][SW-1] ? SW'(-sraw[i]) : SW'(sraw[i]);
        rnd = (64'(mag) + (64'(1) << (COORD_FRAC_BITS - 3))) >> (COORD_FRAC_BITS - 2);
        dm1_q[i]  <= rnd[30:0];
        big1_q[i] <= |rnd[63:31];
        dsq2_q[i] <= 62'(dm1_q[i]) * 62'(dm1_q[i]);
      end
      big2_q   <= |big1_q;
      degen3_q <= !big2_q &&
                  ((64'(dsq2_q[0]) + 64'(dsq2_q[1]) + 64'(dsq2_q[2])) < lavm_pkg::DEGEN_LIMIT);
    end
  end

  lavm_dly #(.W(1), .D(NL - DL)) u_dly_dgn (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (degen3_q),
    .q_o  (degen_d)
  );

  logic            vld_s;
  lavm_pkg::unit_t ns_v [3];

  lavm_norm #(.WI(SW)) u_nrm_side (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_c1),
    .v_i   (sraw),
    .vld_o (vld_s),
    .u_o   (ns_v)
  );

  // side select
  logic            vld_ss_q;
  lavm_pkg::unit_t s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_ss_q <= 1'b0;
    end else if (en) begin
      vld_ss_q <= vld_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (degen_d) begin
        s_q[0] <= lavm_pkg::UNIT_ONE;
        s_q[1] <= '0;
        s_q[2] <= '0;
      end else begin
        s_q <= ns_v;
      end
    end
  end

  logic [3*UW-1:0] f_bq;
  lavm_pkg::unit_t f_b [3];

  lavm_dly #(.W(3*UW), .D(D_F1)) u_dly_f1 (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({f_v[2], f_v[1], f_v[0]}),
    .q_o  (f_bq)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_b[i] = $signed(f_bq[i*UW +: UW]);
    end
  end

  // true up vector
  logic                 vld_c2;
  logic signed [TW-1:0] uraw [3];

  lavm_cross #(.WA(UW), .WB(UW)) u_crs_up (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_ss_q),
    .a_i   (s_q),
    .b_i   (f_b),
    .vld_o (vld_c2),
    .o_o   (uraw)
  );

  logic            vld_u;
  lavm_pkg::unit_t u_v [3];

  lavm_norm #(.WI(TW)) u_nrm_up (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_c2),
    .v_i   (uraw),
    .vld_o (vld_u),
    .u_o   (u_v)
  );

  // line everything up with the true up vector
  logic [3*UW-1:0] s_cq, f_cq;
  logic [3*CW-1:0] eye_cq;
  lavm_pkg::unit_t rows [3][3];
  lavm_pkg::coord_t eye_c [3];

  lavm_dly #(.W(3*UW), .D(D_S)) u_dly_s (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({s_q[2], s_q[1], s_q[0]}),
    .q_o  (s_cq)
  );

  lavm_dly #(.W(3*UW), .D(D_S)) u_dly_f2 (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (f_bq),
    .q_o  (f_cq)
  );

  lavm_dly #(.W(3*CW), .D(D_EYE)) u_dly_eye (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({eye_a_q[2], eye_a_q[1], eye_a_q[0]}),
    .q_o  (eye_cq)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rows[0][i] = $signed(s_cq[i*UW +: UW]);
      rows[1][i] = u_v[i];
      rows[2][i] = $signed(f_cq[i*UW +: UW]);
      eye_c[i]   = $signed(eye_cq[i*CW +: CW]);
    end
  end

  // output stages: products, dot sums, rounding
  logic                 vld_o1_q, vld_o2_q;
  logic signed [PW-1:0] pr_q [3][3];
  lavm_pkg::rot_t       rot1_q [3][3];
  lavm_pkg::rot_t       rot2_q [3][3];
  logic signed [63:0]   nd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o1_q    <= 1'b0;
      vld_o2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_o1_q    <= vld_u;
      vld_o2_q    <= vld_o1_q;
      out_valid_q <= vld_o2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          pr_q[r][i]   <= PW'(rows[r][i]) * PW'(eye_c[i]);
          rot1_q[r][i] <= rnd_rot(rows[r][i]);
        end
        nd_q[r] <= -(64'(pr_q[r][0]) + 64'(pr_q[r][1]) + 64'(pr_q[r][2]));
      end
      rot2_q <= rot1_q;
      out_data_q.side_x     <= rot2_q[0][0];
      out_data_q.side_y     <= rot2_q[0][1];
      out_data_q.side_z     <= rot2_q[0][2];
      out_data_q.trueup_x   <= rot2_q[1][0];
      out_data_q.trueup_y   <= rot2_q[1][1];
      out_data_q.trueup_z   <= rot2_q[1][2];
      out_data_q.fwd_x      <= rot2_q[2][0];
      out_data_q.fwd_y      <= rot2_q[2][1];
      out_data_q.fwd_z      <= rot2_q[2][2];
      out_data_q.shift_side <= rnd_shift(nd_q[0]);
      out_data_q.shift_up   <= rnd_shift(nd_q[1]);
      out_data_q.shift_fwd  <= rnd_shift(nd_q[2]);
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hw/rtl/lavm_dly.sv @@
// enabled shift-register delay line
module lavm_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

@@ hw/rtl/lavm_cross.sv @@
// two-stage pipelined cross product
module lavm_cross #(
  parameter int unsigned WA = 30,
  parameter int unsigned WB = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [WA-1:0] a_i [3],
  input  logic signed [WB-1:0] b_i [3],
  output logic                 vld_o,
  output logic signed [WA+WB:0] o_o [3]
);

  localparam int unsigned WP = WA + WB;

  logic              vld1_q, vld2_q;
  logic signed [WP-1:0] p_q [6];
  logic signed [WP:0]   o_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= WP'(a_i[1]) * WP'(b_i[2]);
      p_q[1] <= WP'(a_i[2]) * WP'(b_i[1]);
      p_q[2] <= WP'(a_i[2]) * WP'(b_i[0]);
      p_q[3] <= WP'(a_i[0]) * WP'(b_i[2]);
      p_q[4] <= WP'(a_i[0]) * WP'(b_i[1]);
      p_q[5] <= WP'(a_i[1]) * WP'(b_i[0]);
      o_q[0] <= (WP+1)'(p_q[0]) - (WP+1)'(p_q[1]);
      o_q[1] <= (WP+1)'(p_q[2]) - (WP+1)'(p_q[3]);
      o_q[2] <= (WP+1)'(p_q[4]) - (WP+1)'(p_q[5]);
    end
  end

  assign vld_o = vld2_q;
  assign o_o   = o_q;

endmodule

@@ hw/rtl/lavm_norm.sv @@
// pipelined vector normalizer: scale, sum of squares, bit-serial sqrt, divide
module lavm_norm #(
  parameter int unsigned WI = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [WI-1:0] v_i [3],
  output logic                 vld_o,
  output lavm_pkg::unit_t      u_o [3]
);

  localparam int unsigned MW   = lavm_pkg::NRM_W;
  localparam int unsigned TOPB = MW - 1;
  localparam int unsigned NG   = (WI + 7) / 8;
  localparam int unsigned PW   = $clog2(WI);
  localparam int unsigned SUMW = 2 * MW + 2;
  localparam int unsigned SQN  = SUMW / 2;
  localparam int unsigned RTW  = SQN;
  localparam int unsigned RMW  = RTW + 3;
  localparam int unsigned DVN  = lavm_pkg::UNIT_BITS + 1;
  localparam int unsigned NUMW = MW + DVN;
  localparam int unsigned UW   = lavm_pkg::UNIT_W;

  // stage 1: magnitudes
  logic          vld1_q;
  logic [WI-1:0] mag1_q [3];
  logic [2:0]    neg1_q;
  // stage 2: per-byte leading one
  logic          vld2_q;
  logic [WI-1:0] mag2_q [3];
  logic [2:0]    neg2_q;
  logic [NG-1:0] gnz_d, gnz2_q;
  logic [2:0]    gpos_d [NG];
  logic [2:0]    gpos2_q [NG];
  logic [WI-1:0] orv;
  logic [NG*8-1:0] orp;
  // stage 3: leading one position
  logic          vld3_q;
  logic [WI-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  logic [PW-1:0] p_d, p3_q;
  logic          zero3_q;
  // stage 4: scaled magnitudes
  logic          vld4_q;
  logic [MW-1:0] m4_q [3];
  logic [MW-1:0] m4_d [3];
  logic [2:0]    neg4_q;
  logic          zero4_q;
  // stage 5: squares
  logic            vld5_q;
  logic [2*MW-1:0] sq5_q [3];
  logic [MW-1:0]   m5_q [3];
  logic [2:0]      neg5_q;
  logic            zero5_q;
  // stage 6: sum
  logic            vld6_q;
  logic [SUMW-1:0] sum6_q;
  logic [MW-1:0]   m6_q [3];
  logic [2:0]      neg6_q;
  logic            zero6_q;
  // square root stages
  logic            sq_vld_q  [SQN];
  logic [RMW-1:0]  sq_rem_q  [SQN];
  logic [RTW-1:0]  sq_root_q [SQN];
  logic [SUMW-1:0] sq_rad_q  [SQN];
  logic [MW-1:0]   sq_m_q    [SQN][3];
  logic [2:0]      sq_neg_q  [SQN];
  logic            sq_zero_q [SQN];
  // divide stages
  logic            dv_vld_q  [DVN];
  logic [RTW-1:0]  dv_len_q  [DVN];
  logic [RTW-1:0]  dv_rem_q  [DVN][3];
  logic [DVN-1:0]  dv_lo_q   [DVN][3];
  logic [DVN-1:0]  dv_quo_q  [DVN][3];
  logic [2:0]      dv_neg_q  [DVN];
  logic            dv_zero_q [DVN];
  // output
  logic            vld_q;
  lavm_pkg::unit_t u_q [3];

  always_comb begin
    orv = mag1_q[0] | mag1_q[1] | mag1_q[2];
    orp = (NG*8)'(orv);
    for (int g = 0; g < NG; g++) begin
      gnz_d[g]  = |orp[g*8 +: 8];
      gpos_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orp[g*8+b]) gpos_d[g] = 3'(b);
      end
    end
  end

  always_comb begin
    p_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz2_q[g]) p_d = PW'(g * 8) + PW'(gpos2_q[g]);
    end
  end

  // bring the leading one to bit TOPB, right shifts truncate
  always_comb begin
    logic [WI+MW-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = (WI+MW)'(mag3_q[i]);
      if (p3_q >= PW'(TOPB)) begin
        wide = wide >> (p3_q - PW'(TOPB));
      end else begin
        wide = wide << (PW'(TOPB) - p3_q);
      end
      m4_d[i] = wide[MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= v_i[i][WI-1] ? WI'(-v_i[i]) : WI'(v_i[i]);
        neg1_q[i] <= v_i[i][WI-1];
      end
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      gnz2_q  <= gnz_d;
      gpos2_q <= gpos_d;
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      p3_q    <= p_d;
      zero3_q <= ~|gnz2_q;
      m4_q    <= m4_d;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= (2*MW)'(m4_q[i]) * (2*MW)'(m4_q[i]);
      end
      m5_q    <= m4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      sum6_q  <= SUMW'(sq5_q[0]) + SUMW'(sq5_q[1]) + SUMW'(sq5_q[2]);
      m6_q    <= m5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // floor square root, two radicand bits per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    logic            vld_in, zero_in;
    logic [RMW-1:0]  rem_in, cand, trial;
    logic [RTW-1:0]  root_in;
    logic [SUMW-1:0] rad_in;
    logic [MW-1:0]   m_in [3];
    logic [2:0]      neg_in;

    if (k == 0) begin : g_first
      assign vld_in  = vld6_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum6_q;
      assign m_in    = m6_q;
      assign neg_in  = neg6_q;
      assign zero_in = zero6_q;
    end else begin : g_next
      assign vld_in  = sq_vld_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign m_in    = sq_m_q[k-1];
      assign neg_in  = sq_neg_q[k-1];
      assign zero_in = sq_zero_q[k-1];
    end

    assign cand  = {rem_in[RMW-3:0], rad_in[SUMW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cand >= trial) begin
          sq_rem_q[k]  <= cand - trial;
          sq_root_q[k] <= {root_in[RTW-2:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= cand;
          sq_root_q[k] <= {root_in[RTW-2:0], 1'b0};
        end
        sq_rad_q[k]  <= {rad_in[SUMW-3:0], 2'b00};
        sq_m_q[k]    <= m_in;
        sq_neg_q[k]  <= neg_in;
        sq_zero_q[k] <= zero_in;
      end
    end
  end

  // restoring divide of (m << 28) + len/2 by len, one quotient bit per stage
  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic           vld_in, zero_in;
    logic [RTW-1:0] len_in;
    logic [RTW-1:0] rem_in [3];
    logic [DVN-1:0] lo_in  [3];
    logic [DVN-1:0] quo_in [3];
    logic [2:0]     neg_in;
    logic [RTW:0]   cand   [3];
    logic [2:0]     ge;

    if (j == 0) begin : g_first
      logic [NUMW-1:0] num [3];
      assign vld_in  = sq_vld_q[SQN-1];
      assign len_in  = sq_root_q[SQN-1];
      assign neg_in  = sq_neg_q[SQN-1];
      assign zero_in = sq_zero_q[SQN-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign num[i] = NUMW'({sq_m_q[SQN-1][i], {lavm_pkg::UNIT_BITS{1'b0}}})
                      + NUMW'(len_in[RTW-1:1]);
        assign rem_in[i] = RTW'(num[i][NUMW-1:DVN]);
        assign lo_in[i]  = num[i][DVN-1:0];
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign vld_in  = dv_vld_q[j-1];
      assign len_in  = dv_len_q[j-1];
      assign rem_in  = dv_rem_q[j-1];
      assign lo_in   = dv_lo_q[j-1];
      assign quo_in  = dv_quo_q[j-1];
      assign neg_in  = dv_neg_q[j-1];
      assign zero_in = dv_zero_q[j-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_cmp
      assign cand[i] = {rem_in[i], lo_in[i][DVN-1]};
      assign ge[i]   = cand[i] >= {1'b0, len_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j][i] <= ge[i] ? RTW'(cand[i] - {1'b0, len_in}) : RTW'(cand[i]);
          dv_quo_q[j][i] <= {quo_in[i][DVN-2:0], ge[i]};
          dv_lo_q[j][i]  <= {lo_in[i][DVN-2:0], 1'b0};
        end
        dv_len_q[j]  <= len_in;
        dv_neg_q[j]  <= neg_in;
        dv_zero_q[j] <= zero_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= dv_vld_q[DVN-1];
    end
  end

  // zero-length input stays zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[DVN-1]) begin
          u_q[i] <= '0;
        end else if (dv_neg_q[DVN-1][i]) begin
          u_q[i] <= -UW'(dv_quo_q[DVN-1][i]);
        end else begin
          u_q[i] <= UW'(dv_quo_q[DVN-1][i]);
        end
      end
    end
  end

  assign vld_o = vld_q;
  assign u_o   = u_q;

endmodule

@@ bench/tb_look_at_view_matrix.sv @@
// testbench for look_at_view_matrix: directed table and random view requests, predictor-checked
`timescale 1ns / 100ps

module tb_look_at_view_matrix;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 400;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    lavm_pkg::view_req_t req;
    bit                  typed;
    lavm_pkg::view_mat_t mat;
  } view_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  lavm_pkg::view_req_t in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lavm_pkg::view_mat_t out_data_o;

  lavm_pkg::view_mat_t mat_q[$];
  int                  errs = 0;
  idle_mode_e          idle_mode = IDLE_NONE;

  always #5 clk_i = ~clk_i;

  look_at_view_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint round_shr(longint v, int sh);
    longint unsigned m;
    m = mag(v);
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q.28, zero stays zero
  function automatic void to_unit(input longint v[3], output longint o[3]);
    longint unsigned m[3], top, len;
    for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (top >= (64'd1 << 24)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << 23)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = int_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      top = ((m[i] << lavm_pkg::UNIT_BITS) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(top) : longint'(top);
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic bit side_too_short(longint s[3]);
    longint unsigned m, sum;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = mag(round_shr(s[i], lavm_pkg::UNIT_BITS + FRAC - 30));
      if (m >= (64'd1 << 31)) return 1'b0;
      sum += m * m;
    end
    return sum < lavm_pkg::DEGEN_LIMIT;
  endfunction

  function automatic lavm_pkg::rot_t to_rot(longint v);
    longint r;
    r = round_shr(v, lavm_pkg::UNIT_BITS - lavm_pkg::ROT_FRAC);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return lavm_pkg::rot_t'(r);
  endfunction

  function automatic lavm_pkg::coord_t neg_dot(longint u[3], longint e[3]);
    longint r;
    r = round_shr(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]), lavm_pkg::UNIT_BITS);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return lavm_pkg::coord_t'(r);
  endfunction

  function automatic lavm_pkg::view_mat_t view_of(lavm_pkg::view_req_t q);
    longint eye[3], upv[3], dif[3], f[3], sr[3], s[3], ur[3], u[3];
    lavm_pkg::view_mat_t m;
    eye = '{longint'(q.eye_x), longint'(q.eye_y), longint'(q.eye_z)};
    upv = '{longint'(q.upvec_x), longint'(q.upvec_y), longint'(q.upvec_z)};
    dif = '{longint'(q.target_x) - eye[0], longint'(q.target_y) - eye[1],
            longint'(q.target_z) - eye[2]};
    to_unit(dif, f);
    cross3(f, upv, sr);
    if (side_too_short(sr)) s = '{longint'(1) << lavm_pkg::UNIT_BITS, 0, 0};
    else to_unit(sr, s);
    cross3(s, f, ur);
    to_unit(ur, u);
    m.side_x = to_rot(s[0]);   m.side_y = to_rot(s[1]);   m.side_z = to_rot(s[2]);
    m.trueup_x = to_rot(u[0]); m.trueup_y = to_rot(u[1]); m.trueup_z = to_rot(u[2]);
    m.fwd_x = to_rot(f[0]);    m.fwd_y = to_rot(f[1]);    m.fwd_z = to_rot(f[2]);
    m.shift_side = neg_dot(s, eye);
    m.shift_up = neg_dot(u, eye);
    m.shift_fwd = neg_dot(f, eye);
    return m;
  endfunction

  function automatic lavm_pkg::view_req_t mk_req(longint ex, longint ey, longint ez,
                                                 longint tx, longint ty, longint tz,
                                                 longint ux, longint uy, longint uz);
    lavm_pkg::view_req_t q;
    q = '{lavm_pkg::coord_t'(ex), lavm_pkg::coord_t'(ey), lavm_pkg::coord_t'(ez),
          lavm_pkg::coord_t'(tx), lavm_pkg::coord_t'(ty), lavm_pkg::coord_t'(tz),
          lavm_pkg::coord_t'(ux), lavm_pkg::coord_t'(uy), lavm_pkg::coord_t'(uz)};
    return q;
  endfunction

  function automatic lavm_pkg::view_mat_t side_only(lavm_pkg::coord_t sh);
    lavm_pkg::view_mat_t m;
    m = '0;
    m.side_x = lavm_pkg::rot_t'(1 << lavm_pkg::ROT_FRAC);
    m.shift_side = sh;
    return m;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errs++;
    end
  endtask

  // receiver: stall pattern and result check
  always @(posedge clk_i) begin
    lavm_pkg::view_mat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mat_q.size() == 0) begin
        $error("result with no item outstanding");
        errs++;
      end else begin
        e = mat_q.pop_front();
        check_field("side_x", e.side_x, out_data_o.side_x);
        check_field("side_y", e.side_y, out_data_o.side_y);
        check_field("side_z", e.side_z, out_data_o.side_z);
        check_field("trueup_x", e.trueup_x, out_data_o.trueup_x);
        check_field("trueup_y", e.trueup_y, out_data_o.trueup_y);
        check_field("trueup_z", e.trueup_z, out_data_o.trueup_z);
        check_field("fwd_x", e.fwd_x, out_data_o.fwd_x);
        check_field("fwd_y", e.fwd_y, out_data_o.fwd_y);
        check_field("fwd_z", e.fwd_z, out_data_o.fwd_z);
        check_field("shift_side", e.shift_side, out_data_o.shift_side);
        check_field("shift_up", e.shift_up, out_data_o.shift_up);
        check_field("shift_fwd", e.shift_fwd, out_data_o.shift_fwd);
      end
    end
    case (idle_mode)
      IDLE_RECV: out_stall_i <= $urandom_range(99) < 84;
      IDLE_BOTH: out_stall_i <= $urandom_range(99) < 16;
      default:   out_stall_i <= 1'b0;
    endcase
  end

  task automatic send_item(lavm_pkg::view_req_t q, bit typed, lavm_pkg::view_mat_t m);
    int pct;
    pct = idle_mode == IDLE_SEND ? 84 : idle_mode == IDLE_BOTH ? 16 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    mat_q.push_back(typed ? m : view_of(q));
  endtask

  function automatic longint rand_coord(int kind);
    case (kind)
      0:       return longint'($signed($urandom));
      1:       return longint'($signed($urandom_range(32'h00200000))) - 64'sh00100000;
      default: return longint'($signed($urandom_range(32'h00004000))) - 64'sh00002000;
    endcase
  endfunction

  function automatic lavm_pkg::view_req_t rand_req();
    lavm_pkg::view_req_t q;
    int kind, shape;
    longint k;
    kind = $urandom_range(2);
    shape = $urandom_range(9);
    q = mk_req(rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
               rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
               rand_coord(kind));
    case (shape)
      0: begin // eye on target
        q.target_x = q.eye_x; q.target_y = q.eye_y; q.target_z = q.eye_z;
      end
      1: begin // up zero
        q.upvec_x = '0; q.upvec_y = '0; q.upvec_z = '0;
      end
      2: begin // up parallel to view direction
        k = $urandom_range(3) + 1;
        q.upvec_x = lavm_pkg::coord_t'((longint'(q.target_x) - q.eye_x) / 4 * k);
        q.upvec_y = lavm_pkg::coord_t'((longint'(q.target_y) - q.eye_y) / 4 * k);
        q.upvec_z = lavm_pkg::coord_t'((longint'(q.target_z) - q.eye_z) / 4 * k);
      end
      default: ;
    endcase
    return q;
  endfunction

  initial begin
    view_row_t rows[$];
    rows.push_back('{mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, side_only(0)});
    rows.push_back('{mk_req(-64'sd2147483648, 2147483647, 1, -64'sd2147483648, 2147483647,
                            1, 0, 0, 0), 1'b1,
                     side_only(lavm_pkg::coord_t'(32'h7fffffff))});
    rows.push_back('{mk_req(2147483647, 0, 0, 2147483647, 0, 0, 0, 0, 0), 1'b1,
                     side_only(lavm_pkg::coord_t'(-32'sd2147483647))});
    rows.push_back('{mk_req(5 << 16, 3 << 16, -7 << 16, 5 << 16, 3 << 16, -7 << 16, 0,
                            1 << 16, 0), 1'b1, side_only(lavm_pkg::coord_t'(-(5 << 16)))});
    rows.push_back('{mk_req(0, 0, 0, 0, 0, -(1 << 16), 0, 1 << 16, 0), 1'b0, '0});
    rows.push_back('{mk_req(1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 0, 1 << 16, 0), 1'b0, '0});
    rows.push_back('{mk_req(0, 0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0), 1'b0, '0});
    rows.push_back('{mk_req(0, 0, 0, 0, 1 << 16, 0, 0, -(3 << 16), 0), 1'b0, '0});
    rows.push_back('{mk_req(0, 0, 0, 4 << 16, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk_req(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                            2147483647, 2147483647, 2147483647, 0, 1 << 16, 0), 1'b0, '0});
    rows.push_back('{mk_req(2147483647, 2147483647, 2147483647, -64'sd2147483648,
                            -64'sd2147483648, -64'sd2147483648, 2147483647,
                            -64'sd2147483648, 2147483647), 1'b0, '0});
    rows.push_back('{mk_req(2147483647, -64'sd2147483648, 0, -64'sd2147483648, 2147483647,
                            1, -1, -1, -1), 1'b0, '0});
    rows.push_back('{mk_req(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0});
    rows.push_back('{mk_req(0, 0, 0, 1, 1, 1, 1, 1, 2), 1'b0, '0});
    rows.push_back('{mk_req(-1, -1, -1, 1, 1, 1, 2147483647, 2147483647, 0), 1'b0, '0});
    rows.push_back('{mk_req(1 << 30, -(1 << 30), 1 << 30, 0, 0, 0, 0, 0, 1 << 16),
                     1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].mat);
    // hold off until the directed items have all drained
    in_valid_i <= 1'b0;
    while (mat_q.size() != 0) @(posedge clk_i);
    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      repeat (220) send_item(rand_req(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    idle_mode = IDLE_NONE;
    while (mat_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errs == 0) $display("tb_look_at_view_matrix passed");
    else $display("tb_look_at_view_matrix failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_look_at_view_matrix failed");
    $finish;
  end

endmodule
